>>> rtl/upc_pkg.sv
// ----------------------------------------------------------------------------
// upc_pkg
// Shared types, character codes and helpers for the URI path decoder.
// ----------------------------------------------------------------------------
package upc_pkg;

    localparam int unsigned ByteW = 8;

    localparam logic [ByteW-1:0] ChPercent = 8'h25;
    localparam logic [ByteW-1:0] ChPlus    = 8'h2B;
    localparam logic [ByteW-1:0] ChSpace   = 8'h20;
    localparam logic [ByteW-1:0] ChSlash   = 8'h2F;
    localparam logic [ByteW-1:0] ChDot     = 8'h2E;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ESC  = 2'd1,
        ST_BAD_PATH = 2'd2,
        ST_DOTDOT   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] high_nibble;
        status_t    error_code;
        logic       seen_first_byte;
        logic       prev_was_dot;
    } dec_state_t;

    localparam dec_state_t StateReset = '{
        phase:           PH_PLAIN,
        high_nibble:     4'd0,
        error_code:      ST_OK,
        seen_first_byte: 1'b0,
        prev_was_dot:    1'b0
    };

    typedef struct packed {
        logic             produce;
        logic [ByteW-1:0] out_byte;
        logic             has_byte;
        logic             end_of_path;
        status_t          status;
    } dec_result_t;

    // Strict hex digit: {is_hex, value}
    function automatic logic [4:0] hex_value(input logic [ByteW-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]})
            r = {1'b1, c[3:0]};
        else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

endpackage

>>> rtl/upc_decode.sv
// ----------------------------------------------------------------------------
// upc_decode
// Percent/plus decoding and path checking for one URI byte: next state and
// the result of the transaction.
// ----------------------------------------------------------------------------
module upc_decode
    import upc_pkg::*;
(
    input  dec_state_t       cur,
    input  logic [ByteW-1:0] uri_byte,
    input  logic             is_empty,
    input  logic             last_byte,
    output dec_state_t       nxt,
    output dec_result_t      res
);

    logic [4:0]       hv;
    logic             have;
    logic             emit;
    logic [ByteW-1:0] dec;
    dec_state_t       upd;
    status_t          st;

    assign hv = hex_value(uri_byte);

    always_comb
    begin
        upd  = cur;
        have = 1'b0;
        emit = 1'b0;
        dec  = '0;
        st   = ST_OK;

        if (!is_empty && cur.error_code != ST_BAD_ESC)
        begin
            case (cur.phase)
                PH_PLAIN:
                begin
                    if (uri_byte == ChPercent)
                        upd.phase = PH_HIGH;
                    else
                    begin
                        dec  = (uri_byte == ChPlus) ? ChSpace : uri_byte;
                        have = 1'b1;
                    end
                end
                PH_HIGH:
                begin
                    if (!hv[4])
                    begin
                        upd.error_code = ST_BAD_ESC;
                        upd.phase      = PH_PLAIN;
                    end
                    else
                    begin
                        upd.high_nibble = hv[3:0];
                        upd.phase       = PH_LOW;
                    end
                end
                default:
                begin
                    // second digit; the unused phase code behaves the same
                    if (!hv[4])
                    begin
                        upd.error_code = ST_BAD_ESC;
                        upd.phase      = PH_PLAIN;
                    end
                    else
                    begin
                        dec       = {cur.high_nibble, hv[3:0]};
                        have      = 1'b1;
                        upd.phase = PH_PLAIN;
                    end
                end
            endcase

            if (have && upd.error_code == ST_OK)
            begin
                if (!cur.seen_first_byte && dec != ChSlash)
                    upd.error_code = ST_BAD_PATH;
                else if (cur.prev_was_dot && dec == ChDot)
                    upd.error_code = ST_DOTDOT;
                upd.seen_first_byte = 1'b1;
                upd.prev_was_dot    = (dec == ChDot);
                emit                = (upd.error_code == ST_OK);
            end
        end

        // final status: a pending escape counts as a bad escape
        st = upd.error_code;
        if (st != ST_BAD_ESC && upd.phase != PH_PLAIN)
            st = ST_BAD_ESC;
        if (st == ST_OK && !upd.seen_first_byte)
            st = ST_BAD_PATH;

        nxt = last_byte ? StateReset : upd;

        res.produce     = emit || last_byte;
        res.out_byte    = emit ? dec : '0;
        res.has_byte    = emit;
        res.end_of_path = last_byte;
        res.status      = last_byte ? st : ST_OK;
    end

endmodule

>>> rtl/url_path_decode_check.sv
// Pipeline: an input transaction passes the input register, then the result
//   register; items yielding no result are dropped at the second stage.
// Throughput: one input byte per cycle while out_ready holds, set by the
//   combinational decode between the input register and the result register.
// Reset: rst_n clears both stages and returns the decoder to plain-byte state.
// ----------------------------------------------------------------------------
// url_path_decode_check
// Streaming URI percent decoder with absolute-path and ".." checking.
// ----------------------------------------------------------------------------
module url_path_decode_check
    import upc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [ByteW-1:0] uri_byte,
    input  logic             is_empty,
    input  logic             last_byte,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [ByteW-1:0] out_byte,
    output logic             has_byte,
    output logic             end_of_path,
    output logic [1:0]       status
);

    logic             in_valid_reg;
    logic [ByteW-1:0] uri_byte_reg;
    logic             is_empty_reg;
    logic             last_byte_reg;

    dec_state_t       state_reg;
    dec_state_t       state_next;
    dec_result_t      res_next;

    logic             res_valid_reg;
    logic [ByteW-1:0] out_byte_reg;
    logic             has_byte_reg;
    logic             end_of_path_reg;
    status_t          status_reg;

    logic             advance;
    logic             in_take;
    logic             load_res;

    upc_decode u_decode (
        .cur       (state_reg),
        .uri_byte  (uri_byte_reg),
        .is_empty  (is_empty_reg),
        .last_byte (last_byte_reg),
        .nxt       (state_next),
        .res       (res_next)
    );

    // decoded item may move on only when the result register is empty or being read out
    assign advance  = in_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;
    assign load_res = advance && res_next.produce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= StateReset;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                state_reg <= state_next;

            if (load_res)
                res_valid_reg <= 1'b1;
            else if (out_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            uri_byte_reg  <= uri_byte;
            is_empty_reg  <= is_empty;
            last_byte_reg <= last_byte;
        end
        if (load_res)
        begin
            out_byte_reg    <= res_next.out_byte;
            has_byte_reg    <= res_next.has_byte;
            end_of_path_reg <= res_next.end_of_path;
            status_reg      <= res_next.status;
        end
    end

    assign out_valid   = res_valid_reg;
    assign out_byte    = out_byte_reg;
    assign has_byte    = has_byte_reg;
    assign end_of_path = end_of_path_reg;
    assign status      = status_reg;

endmodule
